// ----- rtl/mlst_pkg.sv -----
`default_nettype none
package mlst_pkg;

  // payload widths
  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 48;
  localparam int QPT_W   = 11;
  localparam int MIN_W   = 49;

  // default number of positions
  localparam int DEF_SIZE = 2048;

  // intercept of the line every node holds after reset
  localparam logic signed [ICPT_W-1:0] EMPTY_ICPT = 48'sd1000000001;

  // command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/mlst_if.sv -----
`default_nettype none
interface mlst_in_if;
  import mlst_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [SLOPE_W-1:0] line_slope;
  logic signed [ICPT_W-1:0]  line_intercept;
  logic        [QPT_W-1:0]   query_point;

  modport source (output valid, cmd, line_slope, line_intercept, query_point, input ready);
  modport sink   (input valid, cmd, line_slope, line_intercept, query_point, output ready);
endinterface

interface mlst_out_if;
  import mlst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [MIN_W-1:0] min_value;

  modport source (output valid, min_value, input ready);
  modport sink   (input valid, min_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/mlst_ram.sv -----
`default_nettype none
module mlst_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 4095
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/min_line_segment_tree_core.sv -----
// insert: a multiply, an add and a compare state per tree level, log2(leaves)+1 levels in all;
//   one node read and at most one write per level
// query: log2(leaves)+1 node reads issued back to back, then the read, multiply and add
//   stages, the running minimum and the output register; one item at a time
// reset: synchronous, active low; a clearing pass writes all 2*leaves-1 nodes
//   before the first beat is taken
`default_nettype none
module min_line_segment_tree_core #(
  parameter int SIZE = mlst_pkg::DEF_SIZE
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mlst_in_if.sink   in_ch,
  mlst_out_if.source out_ch
);
  import mlst_pkg::*;

  localparam int LVL    = $clog2(SIZE);
  localparam int LEAVES = 1 << LVL;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int NW     = $clog2(NODES);
  localparam int QCW    = $clog2(LVL + 2);
  localparam int PW     = SLOPE_W + LVL + 1;
  localparam int VW     = ((PW > ICPT_W) ? PW : ICPT_W) + 1;
  localparam int DW     = SLOPE_W + ICPT_W;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_IMUL = 7'b0000100,
    S_IADD = 7'b0001000,
    S_ICMP = 7'b0010000,
    S_QRY  = 7'b0100000,
    S_QOUT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // walk state
  logic [NW-1:0]  node_r, node_nxt;
  logic [NW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [LVL-1:0] lo_r, lo_nxt;
  logic [LVL-1:0] half_r, half_nxt;
  logic [LVL-1:0] qx_r, qx_nxt;
  logic [QCW-1:0] qleft_r, qleft_nxt;
  logic signed [SLOPE_W-1:0] car_k_r, car_k_nxt;
  logic signed [ICPT_W-1:0]  car_b_r, car_b_nxt;
  logic signed [VW-1:0]      best_r, best_nxt;

  // pipeline flags for the query walk
  logic rd_v_r, rd_last_r, mul_v_r, mul_last_r, add_v_r, add_last_r;
  logic q_issue;

  // memory port
  logic          ram_we;
  logic [NW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic signed [SLOPE_W-1:0] rd_k;
  logic signed [ICPT_W-1:0]  rd_b;

  // multiply and add stage registers
  logic [LVL-1:0] mid, xa;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [SLOPE_W-1:0] sk_r;
  logic signed [ICPT_W-1:0]  sb_r;
  logic signed [VW-1:0] s0_r, s1_r, s2_r, s3_r;
  logic swap, go_left;

  // output register
  logic                    out_valid_r;
  logic signed [MIN_W-1:0] out_min_r;
  logic                    out_free;
  logic                    in_beat;

  mlst_ram #(
    .WIDTH (DW),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_k = ram_rdata[DW-1:ICPT_W];
  assign rd_b = ram_rdata[ICPT_W-1:0];

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_beat          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.min_value = out_min_r;
  assign out_free         = !out_valid_r || out_ch.ready;

  assign mid     = lo_r + half_r;
  assign xa      = (state_r == S_QRY) ? qx_r : mid;
  assign q_issue = (state_r == S_QRY) && (qleft_r != '0);

  // compare results at the node midpoint and left edge
  assign swap    = s1_r < s0_r;
  assign go_left = swap ? (s2_r < s3_r) : (s3_r < s2_r);

  // next state and memory access
  always_comb begin
    state_nxt    = state_r;
    node_nxt     = node_r;
    clr_addr_nxt = clr_addr_r;
    lo_nxt       = lo_r;
    half_nxt     = half_r;
    qx_nxt       = qx_r;
    qleft_nxt    = qleft_r;
    car_k_nxt    = car_k_r;
    car_b_nxt    = car_b_r;
    best_nxt     = best_r;
    ram_we       = 1'b0;
    ram_waddr    = node_r;
    ram_wdata    = {car_k_r, car_b_r};
    ram_raddr    = node_r;
    unique case (state_r)
      S_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = {{SLOPE_W{1'b0}}, EMPTY_ICPT};
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == NW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          if (in_ch.cmd == CMD_INSERT) begin
            node_nxt  = '0;
            ram_raddr = '0;
            lo_nxt    = '0;
            half_nxt  = LVL'(LEAVES / 2);
            car_k_nxt = in_ch.line_slope;
            car_b_nxt = in_ch.line_intercept;
            state_nxt = S_IMUL;
          end else begin
            qx_nxt    = LVL'(in_ch.query_point);
            node_nxt  = NW'(LVL'(in_ch.query_point)) + NW'(LEAVES - 1);
            qleft_nxt = QCW'(LVL + 1);
            best_nxt  = {1'b0, {(VW-1){1'b1}}};
            state_nxt = S_QRY;
          end
        end
      end
      S_IMUL: begin
        state_nxt = S_IADD;
      end
      S_IADD: begin
        state_nxt = S_ICMP;
      end
      S_ICMP: begin
        // keep the lower line at the midpoint, push the other one down
        if (swap) begin
          ram_we    = 1'b1;
          ram_waddr = node_r;
          ram_wdata = {car_k_r, car_b_r};
          car_k_nxt = sk_r;
          car_b_nxt = sb_r;
        end
        if (half_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          if (go_left) begin
            node_nxt = {node_r[NW-2:0], 1'b1};
          end else begin
            node_nxt = {node_r[NW-2:0], 1'b0} + NW'(2);
            lo_nxt   = mid;
          end
          half_nxt  = half_r >> 1;
          ram_raddr = node_nxt;
          state_nxt = S_IMUL;
        end
      end
      S_QRY: begin
        // leaf to root, one read per cycle
        ram_raddr = node_r;
        if (q_issue) begin
          qleft_nxt = qleft_r - 1'b1;
          node_nxt  = (node_r - 1'b1) >> 1;
        end
        if (add_v_r && (s0_r < best_r)) begin
          best_nxt = s0_r;
        end
        if (add_v_r && add_last_r) begin
          state_nxt = S_QOUT;
        end
      end
      S_QOUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      qleft_r     <= '0;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      mul_v_r     <= 1'b0;
      mul_last_r  <= 1'b0;
      add_v_r     <= 1'b0;
      add_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      qleft_r    <= qleft_nxt;
      rd_v_r     <= q_issue;
      rd_last_r  <= q_issue && (qleft_r == QCW'(1));
      mul_v_r    <= rd_v_r;
      mul_last_r <= rd_last_r;
      add_v_r    <= mul_v_r;
      add_last_r <= mul_last_r;
      if (state_r == S_QOUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    lo_r    <= lo_nxt;
    half_r  <= half_nxt;
    qx_r    <= qx_nxt;
    car_k_r <= car_k_nxt;
    car_b_r <= car_b_nxt;
    best_r  <= best_nxt;
    if (state_r == S_QOUT && out_free) begin
      out_min_r <= best_r[MIN_W-1:0];
    end
  end

  // multiply stage: stored and carried line at the midpoint (the query point in a query) and the left edge
  always_ff @(posedge clk) begin
    if (rd_v_r || state_r == S_IMUL) begin
      p0_r <= PW'(rd_k) * PW'($signed({1'b0, xa}));
      p1_r <= PW'(car_k_r) * PW'($signed({1'b0, xa}));
      p2_r <= PW'(rd_k) * PW'($signed({1'b0, lo_r}));
      p3_r <= PW'(car_k_r) * PW'($signed({1'b0, lo_r}));
      sk_r <= rd_k;
      sb_r <= rd_b;
    end
  end

  // add stage
  always_ff @(posedge clk) begin
    if (mul_v_r || state_r == S_IADD) begin
      s0_r <= VW'(p0_r) + VW'(sb_r);
      s1_r <= VW'(p1_r) + VW'(car_b_r);
      s2_r <= VW'(p2_r) + VW'(sb_r);
      s3_r <= VW'(p3_r) + VW'(car_b_r);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mlst_chk.sv -----
`default_nettype none
module mlst_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [mlst_pkg::MIN_W-1:0]   out_min_value
);
  import mlst_pkg::*;

  // reset holds both sides closed
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ports not quiet after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_value))
    else $error("result beat dropped or changed while stalled");

  // one item at a time: busy right after a beat is taken
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a result only comes out of a busy walk
  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no query in flight");

endmodule

bind min_line_segment_tree_core mlst_chk u_mlst_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_min_value (out_ch.min_value)
);
`default_nettype wire
